>>> rtl/rmsm_pkg.sv
// ----------------------------------------------------------------------------
// rmsm_pkg
// Types and constants for the maze set-merge block.
// ----------------------------------------------------------------------------
package rmsm_pkg;

  localparam int unsigned MaxSide   = 16;
  localparam int unsigned NumCells  = MaxSide * MaxSide;
  localparam int unsigned CellAw    = $clog2(NumCells);
  localparam int unsigned CountW    = CellAw + 1;
  localparam int unsigned CoordW    = $clog2(MaxSide);
  localparam int unsigned SideW     = CoordW + 1;
  localparam int unsigned RunCntW   = 20;
  localparam logic [RunCntW-1:0] RunLimit = 20'd1000000;
  localparam logic [31:0] LfsrTaps  = 32'h8020_0003;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_STEP    = 2'd1,
    OP_RUN     = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    DIR_NONE   = 3'd0,
    DIR_LEFT   = 3'd1,
    DIR_RIGHT  = 3'd2,
    DIR_TOP    = 3'd3,
    DIR_BOTTOM = 3'd4
  } dir_e;

  typedef enum logic {
    CFG_GRID_SIZE = 1'b0,
    CFG_RNG_SEED  = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_RDK,
    ST_RDC,
    ST_MARK,
    ST_NB,
    ST_NB2,
    ST_DECIDE,
    ST_SWEEP,
    ST_SHIFT,
    ST_SHIFT2,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              marked;
    logic [CellAw-1:0] label;
    logic [3:0]        walls;
  } cell_t;

endpackage

>>> rtl/rmsm_ram.sv
// ----------------------------------------------------------------------------
// rmsm_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rmsm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/random_maze_set_merge.sv
// ----------------------------------------------------------------------------
// random_maze_set_merge
// Randomized Kruskal maze builder whose cell state lives in a cell RAM and an
// active-list RAM, both with a registered read port.
// ----------------------------------------------------------------------------
// Restart and reset run a clearing pass over every entry of the cell RAM.
// A step draws an active cell and reads its neighbours; on a merge it draws
// a second time and runs the relabel sweep over the cell RAM, and on a drop
// it shifts the later active-list entries down by one.
// The remainder unit (one bit per cycle) and the single cell RAM read port set the
// step time. One item is in work at a time.
// After reset the block clears its memories and then accepts transfers.
// ----------------------------------------------------------------------------
module random_maze_set_merge (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // cell_x, cell_y
  input  logic [1:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // step_cell_x, step_cell_y, merged, wall_dir, sets_left, active_left,
  // maze_done, cell_walls
  output logic [39:0] m_axis_tdata
);

  import rmsm_pkg::*;

  function automatic logic [31:0] lfsr_next(input logic [31:0] v);
    lfsr_next = v[0] ? ((v >> 1) ^ LfsrTaps) : (v >> 1);
  endfunction

  function automatic logic [CellAw-1:0] nb_addr(input logic [CellAw-1:0] c,
                                                input logic [1:0] i);
    logic [CellAw-1:0] r;
    case (i)
      2'd0:    r = c - CellAw'(MaxSide);
      2'd1:    r = c + CellAw'(MaxSide);
      2'd2:    r = c - CellAw'(1);
      default: r = c + CellAw'(1);
    endcase
    nb_addr = r;
  endfunction

  state_e            state_q, state_d;
  logic [4:0]        grid_size_q, grid_size_d;
  logic [31:0]       seed_q, seed_d;
  logic [SideW-1:0]  side_q, side_d;
  logic [CountW-1:0] act_cnt_q, act_cnt_d, set_cnt_q, set_cnt_d;
  logic [31:0]       lfsr_q, lfsr_d;
  logic              done_q, done_d, reply_q, reply_d, run_q, run_d;
  logic [CoordW-1:0] last_x_q, last_x_d, last_y_q, last_y_d;
  logic [CoordW-1:0] rx_q, rx_d, ry_q, ry_d;
  logic              merged_q, merged_d;
  logic [2:0]        ldir_q, ldir_d, mdir_q, mdir_d;
  logic [3:0]        cw_q, cw_d;
  logic [CountW-1:0] ptr_q, ptr_d;
  logic [SideW-1:0]  ax_q, ax_d, ay_q, ay_d;
  logic [CellAw-1:0] k_q, k_d, c_q, c_d, n_q, n_d;
  logic [CellAw-1:0] lab_c_q, lab_c_d, from_q, from_d;
  logic [1:0]        nbi_q, nbi_d;
  logic              nm_q, nm_d, sel_q, sel_d;
  logic [2:0]        nd_q, nd_d;
  logic [CellAw-1:0] cand_lab_q [4];
  logic [CellAw-1:0] cand_lab_d [4];
  logic [2:0]        cand_dir_q [4];
  logic [2:0]        cand_dir_d [4];
  logic [CountW-1:0] rem_q, rem_d, divr_q, divr_d;
  logic [31:0]       dvd_q, dvd_d;
  logic [4:0]        dcnt_q, dcnt_d;
  logic [RunCntW-1:0] run_cnt_q, run_cnt_d;
  logic              m_valid_q, m_valid_d;
  logic [39:0]       m_data_q, m_data_d;

  logic              cr_we, lr_we;
  logic [CellAw-1:0] cr_wa, cr_ra, lr_wa, lr_ra;
  cell_t             cr_wd, cr_rd;
  logic [CellAw-1:0] lr_wd, lr_rd;

  logic [SideW-1:0]  new_side;
  logic [2*SideW-1:0] side_sq;
  logic [CountW:0]   rem_sh;
  logic [CellAw-1:0] sw_addr;
  logic [3:0]        c_mask, n_mask;
  logic              nb_ok;
  logic [CoordW-1:0] cx, cy;
  cell_t             sw_cell;
  logic              in_acc;

  rmsm_ram #(.Width($bits(cell_t)), .Depth(NumCells)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cr_we),
    .waddr_i (cr_wa),
    .wdata_i (cr_wd),
    .raddr_i (cr_ra),
    .rdata_o (cr_rd)
  );

  rmsm_ram #(.Width(CellAw), .Depth(NumCells)) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (lr_we),
    .waddr_i (lr_wa),
    .wdata_i (lr_wd),
    .raddr_i (lr_ra),
    .rdata_o (lr_rd)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cx            = c_q[CellAw-1:CoordW];
  assign cy            = c_q[CoordW-1:0];

  always_comb begin
    if (grid_size_q < 5'd2) begin
      new_side = SideW'(2);
    end else if (grid_size_q > 5'(MaxSide)) begin
      new_side = SideW'(MaxSide);
    end else begin
      new_side = SideW'(grid_size_q);
    end
    side_sq = new_side * new_side;
  end

  always_comb begin
    case (nbi_q)
      2'd0:    nb_ok = (cx != '0);
      2'd1:    nb_ok = ({1'b0, cx} + SideW'(1)) < side_q;
      2'd2:    nb_ok = (cy != '0);
      default: nb_ok = ({1'b0, cy} + SideW'(1)) < side_q;
    endcase
  end

  always_comb begin
    case (mdir_q)
      DIR_LEFT:  begin c_mask = 4'b0001; n_mask = 4'b0010; end
      DIR_RIGHT: begin c_mask = 4'b0010; n_mask = 4'b0001; end
      DIR_TOP:   begin c_mask = 4'b0100; n_mask = 4'b1000; end
      default:   begin c_mask = 4'b1000; n_mask = 4'b0100; end
    endcase
    sw_addr = ptr_q[CellAw-1:0] - CellAw'(1);
    sw_cell = cr_rd;
    if (cr_rd.label == from_q) begin
      sw_cell.label = lab_c_q;
    end
    if (sw_addr == c_q) begin
      sw_cell.walls = sw_cell.walls & ~c_mask;
    end
    if (sw_addr == n_q) begin
      sw_cell.walls = sw_cell.walls & ~n_mask;
    end
  end

  always_comb begin
    state_d     = state_q;
    grid_size_d = grid_size_q;
    seed_d      = seed_q;
    side_d      = side_q;
    act_cnt_d   = act_cnt_q;
    set_cnt_d   = set_cnt_q;
    lfsr_d      = lfsr_q;
    done_d      = done_q;
    reply_d     = reply_q;
    run_d       = run_q;
    last_x_d    = last_x_q;
    last_y_d    = last_y_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    merged_d    = merged_q;
    ldir_d      = ldir_q;
    mdir_d      = mdir_q;
    cw_d        = cw_q;
    ptr_d       = ptr_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    k_d         = k_q;
    c_d         = c_q;
    n_d         = n_q;
    lab_c_d     = lab_c_q;
    from_d      = from_q;
    nbi_d       = nbi_q;
    nm_d        = nm_q;
    sel_d       = sel_q;
    nd_d        = nd_q;
    cand_lab_d  = cand_lab_q;
    cand_dir_d  = cand_dir_q;
    rem_d       = rem_q;
    divr_d      = divr_q;
    dvd_d       = dvd_q;
    dcnt_d      = dcnt_q;
    run_cnt_d   = run_cnt_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;
    cr_we       = 1'b0;
    cr_wa       = c_q;
    cr_wd       = cr_rd;
    cr_ra       = c_q;
    lr_we       = 1'b0;
    lr_wa       = ptr_q[CellAw-1:0];
    lr_wd       = {ax_q[CoordW-1:0], ay_q[CoordW-1:0]};
    lr_ra       = k_q;
    rem_sh      = {rem_q, dvd_q[31]};

    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_GRID_SIZE) begin
        grid_size_d = cfg_data_i[4:0];
      end else begin
        seed_d = cfg_data_i;
      end
    end

    case (state_q)
      ST_CLR: begin
        cr_we = 1'b1;
        cr_wa = ptr_q[CellAw-1:0];
        cr_wd = '{marked: 1'b0, label: ptr_q[CellAw-1:0], walls: 4'hF};
        if (ptr_q < act_cnt_q) begin
          lr_we = 1'b1;
          if (ay_q + SideW'(1) == side_q) begin
            ay_d = '0;
            ax_d = ax_q + SideW'(1);
          end else begin
            ay_d = ay_q + SideW'(1);
          end
        end
        ptr_d = ptr_q + CountW'(1);
        if (ptr_q == CountW'(NumCells - 1)) begin
          state_d = reply_q ? ST_OUT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        cr_ra = s_axis_tdata;
        if (in_acc) begin
          cw_d      = '0;
          run_cnt_d = '0;
          run_d     = (s_axis_tuser == OP_RUN);
          rx_d      = s_axis_tdata[CoordW-1:0];
          ry_d      = s_axis_tdata[2*CoordW-1:CoordW];
          cr_ra     = {s_axis_tdata[CoordW-1:0], s_axis_tdata[2*CoordW-1:CoordW]};
          case (s_axis_tuser)
            OP_RESTART: begin
              side_d    = new_side;
              act_cnt_d = side_sq[CountW-1:0];
              set_cnt_d = side_sq[CountW-1:0];
              lfsr_d    = (seed_q != '0) ? seed_q : 32'd1;
              done_d    = 1'b0;
              last_x_d  = '0;
              last_y_d  = '0;
              merged_d  = 1'b0;
              ldir_d    = DIR_NONE;
              ptr_d     = '0;
              ax_d      = '0;
              ay_d      = '0;
              reply_d   = 1'b1;
              state_d   = ST_CLR;
            end
            OP_READ: state_d = ST_READ;
            default: state_d = ST_CHECK;
          endcase
        end
      end
      ST_READ: begin
        if (({1'b0, rx_q} < side_q) && ({1'b0, ry_q} < side_q)) begin
          cw_d = cr_rd.walls;
        end
        state_d = ST_OUT;
      end
      ST_CHECK: begin
        if ((set_cnt_q > CountW'(1)) && (act_cnt_q != '0) &&
            (run_cnt_q < (run_q ? RunLimit : RunCntW'(1)))) begin
          run_cnt_d = run_cnt_q + RunCntW'(1);
          lfsr_d    = lfsr_next(lfsr_q);
          dvd_d     = lfsr_next(lfsr_q);
          rem_d     = '0;
          divr_d    = act_cnt_q;
          dcnt_d    = 5'd31;
          sel_d     = 1'b0;
          state_d   = ST_DIV;
        end else begin
          if (set_cnt_q <= CountW'(1)) begin
            done_d = 1'b1;
          end
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (rem_sh >= {1'b0, divr_q}) begin
          rem_d = CountW'(rem_sh - {1'b0, divr_q});
        end else begin
          rem_d = rem_sh[CountW-1:0];
        end
        dvd_d  = dvd_q << 1;
        dcnt_d = dcnt_q - 5'd1;
        if (dcnt_q == '0) begin
          if (!sel_q) begin
            k_d     = rem_d[CellAw-1:0];
            state_d = ST_RDK;
          end else begin
            from_d  = cand_lab_q[rem_d[1:0]];
            mdir_d  = cand_dir_q[rem_d[1:0]];
            n_d     = nb_addr(c_q, 2'(cand_dir_q[rem_d[1:0]] - 3'd1));
            ptr_d   = '0;
            state_d = ST_SWEEP;
          end
        end
      end
      ST_RDK: begin
        lr_ra   = k_q;
        state_d = ST_RDC;
      end
      ST_RDC: begin
        c_d     = lr_rd;
        cr_ra   = lr_rd;
        state_d = ST_MARK;
      end
      ST_MARK: begin
        cr_we     = 1'b1;
        cr_wa     = c_q;
        cr_wd     = cr_rd;
        cr_wd.marked = 1'b1;
        lab_c_d   = cr_rd.label;
        last_x_d  = cx;
        last_y_d  = cy;
        merged_d  = 1'b0;
        ldir_d    = DIR_NONE;
        nd_d      = '0;
        nm_d      = 1'b0;
        nbi_d     = '0;
        state_d   = ST_NB;
      end
      ST_NB: begin
        cr_ra = nb_addr(c_q, nbi_q);
        if (nb_ok) begin
          state_d = ST_NB2;
        end else if (nbi_q == 2'd3) begin
          state_d = ST_DECIDE;
        end else begin
          nbi_d = nbi_q + 2'd1;
        end
      end
      ST_NB2: begin
        if (cr_rd.marked) begin
          nm_d = 1'b1;
          if (cr_rd.label != lab_c_q) begin
            cand_lab_d[nd_q[1:0]] = cr_rd.label;
            cand_dir_d[nd_q[1:0]] = {1'b0, nbi_q} + 3'd1;
            nd_d = nd_q + 3'd1;
          end
        end
        if (nbi_q == 2'd3) begin
          state_d = ST_DECIDE;
        end else begin
          nbi_d   = nbi_q + 2'd1;
          state_d = ST_NB;
        end
      end
      ST_DECIDE: begin
        if (!nm_q) begin
          state_d = ST_CHECK;
        end else if (nd_q != '0) begin
          lfsr_d  = lfsr_next(lfsr_q);
          dvd_d   = lfsr_next(lfsr_q);
          rem_d   = '0;
          divr_d  = CountW'(nd_q);
          dcnt_d  = 5'd31;
          sel_d   = 1'b1;
          state_d = ST_DIV;
        end else begin
          ptr_d   = CountW'(k_q) + CountW'(1);
          state_d = ST_SHIFT;
        end
      end
      ST_SWEEP: begin
        cr_ra = ptr_q[CellAw-1:0];
        if (ptr_q != '0) begin
          cr_we = 1'b1;
          cr_wa = sw_addr;
          cr_wd = sw_cell;
        end
        ptr_d = ptr_q + CountW'(1);
        if (ptr_q == CountW'(NumCells)) begin
          if (set_cnt_q != '0) begin
            set_cnt_d = set_cnt_q - CountW'(1);
          end
          merged_d = 1'b1;
          ldir_d   = mdir_q;
          state_d  = ST_CHECK;
        end
      end
      ST_SHIFT: begin
        lr_ra = ptr_q[CellAw-1:0];
        if (ptr_q < act_cnt_q) begin
          state_d = ST_SHIFT2;
        end else begin
          act_cnt_d = act_cnt_q - CountW'(1);
          state_d   = ST_CHECK;
        end
      end
      ST_SHIFT2: begin
        lr_we   = 1'b1;
        lr_wa   = ptr_q[CellAw-1:0] - CellAw'(1);
        lr_wd   = lr_rd;
        ptr_d   = ptr_q + CountW'(1);
        state_d = ST_SHIFT;
      end
      ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {5'd0, cw_q, done_q, act_cnt_q, set_cnt_q, ldir_q, merged_q,
                       last_y_q, last_x_q};
          reply_d   = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      grid_size_q <= 5'd5;
      seed_q      <= 32'd1;
      side_q      <= SideW'(5);
      act_cnt_q   <= CountW'(25);
      set_cnt_q   <= CountW'(25);
      lfsr_q      <= 32'd1;
      done_q      <= 1'b0;
      reply_q     <= 1'b0;
      run_q       <= 1'b0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      merged_q    <= 1'b0;
      ldir_q      <= DIR_NONE;
      ptr_q       <= '0;
      ax_q        <= '0;
      ay_q        <= '0;
      run_cnt_q   <= '0;
      dcnt_q      <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      grid_size_q <= grid_size_d;
      seed_q      <= seed_d;
      side_q      <= side_d;
      act_cnt_q   <= act_cnt_d;
      set_cnt_q   <= set_cnt_d;
      lfsr_q      <= lfsr_d;
      done_q      <= done_d;
      reply_q     <= reply_d;
      run_q       <= run_d;
      last_x_q    <= last_x_d;
      last_y_q    <= last_y_d;
      merged_q    <= merged_d;
      ldir_q      <= ldir_d;
      ptr_q       <= ptr_d;
      ax_q        <= ax_d;
      ay_q        <= ay_d;
      run_cnt_q   <= run_cnt_d;
      dcnt_q      <= dcnt_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q       <= rx_d;
    ry_q       <= ry_d;
    mdir_q     <= mdir_d;
    cw_q       <= cw_d;
    k_q        <= k_d;
    c_q        <= c_d;
    n_q        <= n_d;
    lab_c_q    <= lab_c_d;
    from_q     <= from_d;
    nbi_q      <= nbi_d;
    nm_q       <= nm_d;
    sel_q      <= sel_d;
    nd_q       <= nd_d;
    cand_lab_q <= cand_lab_d;
    cand_dir_q <= cand_dir_d;
    rem_q      <= rem_d;
    divr_q     <= divr_d;
    dvd_q      <= dvd_d;
    m_data_q   <= m_data_d;
  end

  a_restart_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == OP_RESTART) |=> (state_q == ST_CLR))
    else $error("Restart did not start the clearing pass.");

  a_sets_never_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_acc && s_axis_tuser == OP_RESTART) |=> (set_cnt_q <= $past(set_cnt_q)))
    else $error("Set count grew without a restart.");

  a_rem_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < divr_q))
    else $error("Remainder out of range.");

  a_list_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT2) |-> (ptr_q < act_cnt_q))
    else $error("List shift read past the active count.");

endmodule
